// ----- src/ssg_pkg.sv -----
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared constants and the CORDIC arctangent table of the sine sample generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_TABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_RADIANS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET        = 3'd4;

    localparam logic [15:0] RST_CYCLES_PER_TABLE = 16'd1;
    localparam logic [14:0] RST_AMPLITUDE        = 15'd2047;
    localparam logic [15:0] RST_PHASE_RADIANS    = 16'd0;
    localparam logic [15:0] RST_TABLE_LENGTH     = 16'd1024;
    localparam logic [15:0] RST_DC_OFFSET        = 16'd2048;

    // round(2^48 / (2*pi)), split in two 24-bit halves
    localparam logic [23:0] INV_TWO_PI_LO = 24'hDB9391;
    localparam logic [23:0] INV_TWO_PI_HI = 24'h28BE60;

    localparam int unsigned CORDIC_XW = 34;
    localparam int unsigned CORDIC_ZW = 33;
    localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int unsigned ANGLE_W = 32;

    typedef logic [1:0] t_quad;
    localparam t_quad QUAD_0 = 2'd0;
    localparam t_quad QUAD_1 = 2'd1;
    localparam t_quad QUAD_2 = 2'd2;
    localparam t_quad QUAD_3 = 2'd3;

    function automatic logic [29:0] atan_turn(input int k);
        logic [29:0] v;
        unique case (k)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667331;
            5:  v = 30'd21354465;
            6:  v = 30'd10679838;
            7:  v = 30'd5340245;
            8:  v = 30'd2670163;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            16: v = 30'd10430;
            17: v = 30'd5215;
            18: v = 30'd2608;
            19: v = 30'd1304;
            20: v = 30'd652;
            21: v = 30'd326;
            22: v = 30'd163;
            23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/ssg_divider.sv -----
// ----------------------------------------------------------------------------
// ssg_divider
// Pipelined restoring divider: table fraction of (index*cycles mod n) / n.
// ----------------------------------------------------------------------------
module ssg_divider #(
    parameter int PHASE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [15:0]           i_index,
    input  logic [15:0]           i_mult,
    input  logic [15:0]           i_divisor,
    output logic                  o_vld,
    output logic [PHASE_BITS-1:0] o_frac
);

    localparam int STEPS = 32 + PHASE_BITS;

    logic             r_vld [0:STEPS];
    logic [15:0]      r_rem [0:STEPS];
    logic [STEPS-1:0] r_w   [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rem[0] <= 16'd0;
        r_w[0]   <= {32'(i_index) * 32'(i_mult), {PHASE_BITS{1'b0}}};
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [16:0] t;
        logic        ge;
        logic [15:0] n_rem;
        assign t     = {r_rem[s], r_w[s][STEPS-1]};
        assign ge    = t >= {1'b0, i_divisor};
        assign n_rem = ge ? 16'(t - {1'b0, i_divisor}) : t[15:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1] <= n_rem;
            r_w[s+1]   <= {r_w[s][STEPS-2:0], ge};
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_frac = r_w[STEPS][PHASE_BITS-1:0];

endmodule

// ----- src/ssg_cordic.sv -----
// ----------------------------------------------------------------------------
// ssg_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration, Q30 sine.
// ----------------------------------------------------------------------------
module ssg_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  logic [ssg_pkg::ANGLE_W-1:0]           i_angle,
    output logic                                  o_vld,
    output logic signed [ssg_pkg::CORDIC_XW-1:0]  o_sine
);

    localparam int XW = ssg_pkg::CORDIC_XW;
    localparam int ZW = ssg_pkg::CORDIC_ZW;

    logic                 r_vld [0:CORDIC_STAGES];
    logic signed [XW-1:0] r_x   [0:CORDIC_STAGES];
    logic signed [XW-1:0] r_y   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_z   [0:CORDIC_STAGES];
    ssg_pkg::t_quad       r_q   [0:CORDIC_STAGES];
    logic                 r_out_vld;
    logic signed [XW-1:0] r_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_x[0] <= ssg_pkg::CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= $signed({3'b000, i_angle[29:0]});
        r_q[0] <= i_angle[31:30];
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;
        assign at = $signed({3'b000, ssg_pkg::atan_turn(k)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            if (!r_z[k][ZW-1]) begin
                r_x[k+1] <= r_x[k] - dx;
                r_y[k+1] <= r_y[k] + dy;
                r_z[k+1] <= r_z[k] - at;
            end else begin
                r_x[k+1] <= r_x[k] + dx;
                r_y[k+1] <= r_y[k] - dy;
                r_z[k+1] <= r_z[k] + at;
            end
            r_q[k+1] <= r_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[CORDIC_STAGES];
        end
        unique case (r_q[CORDIC_STAGES])
            ssg_pkg::QUAD_0: r_sine <= r_y[CORDIC_STAGES];
            ssg_pkg::QUAD_1: r_sine <= r_x[CORDIC_STAGES];
            ssg_pkg::QUAD_2: r_sine <= -r_y[CORDIC_STAGES];
            ssg_pkg::QUAD_3: r_sine <= -r_x[CORDIC_STAGES];
        endcase
    end

    assign o_vld  = r_out_vld;
    assign o_sine = r_sine;

endmodule

// ----- src/sine_sample_generator.sv -----
// ----------------------------------------------------------------------------
// sine_sample_generator
// Direct digital synthesis sine sample source with a fully pipelined datapath.
// ----------------------------------------------------------------------------
// One sample index may be started in every clock; busy never rises. Each item
// gives exactly one sample, strobed on o_valid for one cycle, after one stage
// for the index multiply, 32 + PHASE_BITS restoring divider steps, one for the
// phase add, CORDIC_STAGES + 2 for the CORDIC with quadrant select, and two
// for scaling and clamping. The receiver cannot stall; results leave in start
// order.
// Write configuration only while no item is in flight.
module sine_sample_generator #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int PHASE_BITS    = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [15:0]                      i_sample_index,
    output logic                             o_valid,
    output logic [15:0]                      o_sample_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);

    localparam int XW = ssg_pkg::CORDIC_XW;
    localparam int PW = XW + 16;
    localparam int AW = PW + 1;
    localparam logic [39:0] MAXV = (40'd1 << SAMPLE_WIDTH) - 40'd1;

    logic [15:0] r_cycles;
    logic [14:0] r_amp;
    logic [15:0] r_phase;
    logic [15:0] r_tlen;
    logic [15:0] r_dc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles <= ssg_pkg::RST_CYCLES_PER_TABLE;
            r_amp    <= ssg_pkg::RST_AMPLITUDE;
            r_phase  <= ssg_pkg::RST_PHASE_RADIANS;
            r_tlen   <= ssg_pkg::RST_TABLE_LENGTH;
            r_dc     <= ssg_pkg::RST_DC_OFFSET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ssg_pkg::CFG_CYCLES_PER_TABLE: r_cycles <= i_cfg_data;
                ssg_pkg::CFG_AMPLITUDE:        r_amp    <= i_cfg_data[14:0];
                ssg_pkg::CFG_PHASE_RADIANS:    r_phase  <= i_cfg_data;
                ssg_pkg::CFG_TABLE_LENGTH:     r_tlen   <= i_cfg_data;
                ssg_pkg::CFG_DC_OFFSET:        r_dc     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // phase word follows the register via the registered products r_ph_lo/r_ph_hi, then r_ph
    logic signed [40:0] r_ph_lo;
    logic signed [40:0] r_ph_hi;
    logic [47:0]        r_ph;

    always_ff @(posedge i_clk) begin
        r_ph_lo <= $signed(r_phase) * $signed({1'b0, ssg_pkg::INV_TWO_PI_LO});
        r_ph_hi <= $signed(r_phase) * $signed({1'b0, ssg_pkg::INV_TWO_PI_HI});
        r_ph    <= 48'({{7{r_ph_lo[40]}}, r_ph_lo}) + {r_ph_hi[23:0], 24'd0};
    end

    logic [15:0]           divisor;
    logic                  div_vld;
    logic [PHASE_BITS-1:0] div_frac;

    assign divisor = (r_tlen == 16'd0) ? 16'd1 : r_tlen;

    ssg_divider #(
        .PHASE_BITS (PHASE_BITS)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (start),
        .i_index   (i_sample_index),
        .i_mult    (r_cycles),
        .i_divisor (divisor),
        .o_vld     (div_vld),
        .o_frac    (div_frac)
    );

    logic [PHASE_BITS-1:0]       ang;
    logic [ssg_pkg::ANGLE_W-1:0] n_a32;
    logic                        r_ang_vld;
    logic [ssg_pkg::ANGLE_W-1:0] r_a32;

    assign ang = div_frac + r_ph[47 -: PHASE_BITS];

    if (PHASE_BITS >= 32) begin : g_a_wide
        assign n_a32 = ang[PHASE_BITS-1 -: 32];
    end else begin : g_a_narrow
        assign n_a32 = {ang, {(32 - PHASE_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_vld <= 1'b0;
        end else begin
            r_ang_vld <= div_vld;
        end
        r_a32 <= n_a32;
    end

    logic                 sin_vld;
    logic signed [XW-1:0] sine;

    ssg_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_ang_vld),
        .i_angle (r_a32),
        .o_vld   (sin_vld),
        .o_sine  (sine)
    );

    logic                 r_mul_vld;
    logic signed [PW-1:0] r_mul;
    logic signed [AW-1:0] acc;
    logic signed [20:0]   val;
    logic signed [39:0]   val_x;
    logic                 r_out_vld;
    logic [15:0]          r_out;
    logic [15:0]          n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else begin
            r_mul_vld <= sin_vld;
        end
        r_mul <= $signed({1'b0, r_amp}) * sine;
    end

    always_comb begin
        acc   = AW'(r_mul) + $signed(AW'({r_dc, 30'd0}));
        val   = acc[50:30];
        val_x = 40'(val);
        if (val[20]) begin
            n_out = 16'd0;
        end else if (val_x > $signed(MAXV)) begin
            n_out = MAXV[15:0];
        end else begin
            n_out = val_x[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_mul_vld;
        end
        r_out <= n_out;
    end

    assign o_valid        = r_out_vld;
    assign o_sample_value = r_out;

endmodule
